// File: hdl/ofdmeq_pkg.sv
// ----------------------------------------------------------------------------
// OFDM carrier equaliser package
// Shared types and constants for the equaliser controller and datapath.
// ----------------------------------------------------------------------------
package ofdmeq_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int NV_W      = 24;
   localparam int SPACING_W = 5;
   localparam int PHASE_W   = 4;
   localparam int INDEX_W   = 10;
   localparam int PROD_W    = 32;
   localparam int NUM_W     = 33;
   localparam int DEN_W     = 33;
   localparam int DIVD_W    = 45;
   localparam int QUO_W     = 17;
   localparam int DIV_STEPS = QUO_W;
   localparam int DCNT_W    = 5;

   localparam logic [SPACING_W-1:0] SPACING_RESET = 5'd4;
   localparam logic [SPACING_W-1:0] SPACING_MAX   = 5'd16;
   localparam logic [NV_W-1:0]      NV_FLOOR      = 24'd1;
   localparam logic [13:0]          FADE_NUM      = 14'd10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_DEN,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } ofdmeq_state_type;

   typedef struct packed {
      logic               capture;
      logic               do_mul;
      logic               do_sum;
      logic               do_den;
      logic               div_load;
      logic               div_step;
      logic               out_load;
      logic [INDEX_W-1:0] data_index;
   } ofdmeq_cmd_type;

   typedef struct packed {
      logic out_blocked;
   } ofdmeq_sts_type;

endpackage

// File: hdl/ofdmeq_if.sv
// ----------------------------------------------------------------------------
// OFDM carrier equaliser channels
// Valid/ready channels for carrier words, result words and the spacing CSR.
// ----------------------------------------------------------------------------
interface ofdmeq_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] y_re;
   logic signed [15:0] y_im;
   logic signed [15:0] h_re;
   logic signed [15:0] h_im;
   logic [23:0]        noise_pwr;
   logic               noise_present;
   logic               last_carrier;

   modport source (output valid, y_re, y_im, h_re, h_im, noise_pwr, noise_present,
                   last_carrier, input ready);
   modport sink   (input valid, y_re, y_im, h_re, h_im, noise_pwr, noise_present,
                   last_carrier, output ready);
endinterface

interface ofdmeq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] eq_re;
   logic signed [15:0] eq_im;
   logic               deep_fade;
   logic [9:0]         data_index;

   modport source (output valid, eq_re, eq_im, deep_fade, data_index, input ready);
   modport sink   (input valid, eq_re, eq_im, deep_fade, data_index, output ready);
endinterface

interface ofdmeq_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] pilot_spacing;

   modport source (output valid, pilot_spacing, input ready);
   modport sink   (input valid, pilot_spacing, output ready);
endinterface

// File: hdl/ofdmeq_div.sv
// ----------------------------------------------------------------------------
// OFDM carrier equaliser divider lane
// Restoring divider, one quotient bit per step, with overflow detect at load.
// ----------------------------------------------------------------------------
module ofdmeq_div (
   input  logic                         clock,
   input  logic                         load,
   input  logic                         step,
   input  logic [ofdmeq_pkg::DIVD_W-1:0] dividend,
   input  logic [ofdmeq_pkg::DEN_W-1:0]  divisor,
   output logic [ofdmeq_pkg::QUO_W-1:0]  quotient,
   output logic                         overflow
);
   import ofdmeq_pkg::*;

   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [QUO_W-1:0] low_ff,  low_in;
   logic [QUO_W-1:0] quo_ff,  quo_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic             ovf_ff,  ovf_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W+1:0] diff;
   logic             ge;

   assign trial = {rem_ff, low_ff[QUO_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};
   assign ge    = ~diff[DEN_W+1];

   always_comb begin
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      ovf_in = ovf_ff;
      if (load) begin
         rem_in = DEN_W'(dividend[DIVD_W-1:QUO_W]);
         low_in = dividend[QUO_W-1:0];
         quo_in = '0;
         den_in = divisor;
         // quotient would not fit in QUO_W bits
         ovf_in = DEN_W'(dividend[DIVD_W-1:QUO_W]) >= divisor;
      end else if (step) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      ovf_ff <= ovf_in;
   end

   assign quotient = quo_ff;
   assign overflow = ovf_ff;

endmodule

// File: hdl/ofdmeq_dp.sv
// ----------------------------------------------------------------------------
// OFDM carrier equaliser datapath
// Products, denominator, deep fade test, two divider lanes and result register.
// ----------------------------------------------------------------------------
module ofdmeq_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  ofdmeq_pkg::ofdmeq_cmd_type       cmd,
   output ofdmeq_pkg::ofdmeq_sts_type       sts,
   input  logic signed [15:0]               req_y_re,
   input  logic signed [15:0]               req_y_im,
   input  logic signed [15:0]               req_h_re,
   input  logic signed [15:0]               req_h_im,
   input  logic [23:0]                      req_noise_pwr,
   input  logic                             req_noise_present,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [15:0]               rsp_eq_re,
   output logic signed [15:0]               rsp_eq_im,
   output logic                             rsp_deep_fade,
   output logic [9:0]                       rsp_data_index
);
   import ofdmeq_pkg::*;

   localparam int NV64_W = NV_W + 6;
   localparam int MAG_W  = NUM_W - 1;
   localparam int FP_W   = PROD_W + 14;

   // saturate a rounded magnitude and apply the sign
   function automatic logic [SAMPLE_W-1:0] sat_sign(input logic [QUO_W-1:0] q,
                                                    input logic ovf, input logic neg);
      logic [SAMPLE_W-1:0] res;
      if (neg) begin
         if (ovf || q > QUO_W'(32768)) res = 16'h8000;
         else                          res = SAMPLE_W'(~q + 1'b1);
      end else begin
         if (ovf || q > QUO_W'(32767)) res = 16'h7FFF;
         else                          res = q[SAMPLE_W-1:0];
      end
      return res;
   endfunction

   logic signed [SAMPLE_W-1:0] y_re_ff, y_im_ff, h_re_ff, h_im_ff;
   logic [NV_W-1:0]            nv_ff;
   logic [INDEX_W-1:0]         idx_ff;
   logic signed [PROD_W-1:0]   p_rr_ff, p_ii_ff, p_ryr_ff, p_iyi_ff, p_ryi_ff, p_iyr_ff;
   logic [PROD_W-1:0]          hm2_ff;
   logic signed [NUM_W-1:0]    num_re_ff, num_im_ff;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic                       fade_ff, fade_in;
   logic                       neg_re_ff, neg_im_ff;
   logic [MAG_W-1:0]           mag_re_ff, mag_im_ff;
   logic [NV64_W-1:0]          nv64;
   logic [FP_W-1:0]            fade_prod;
   logic signed [NUM_W-1:0]    abs_re, abs_im;
   logic [DIVD_W-1:0]          dvd_re, dvd_im;
   logic [QUO_W-1:0]           quo_re, quo_im;
   logic                       ovf_re, ovf_im;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] eq_re_ff, eq_im_ff;
   logic                       fade_out_ff;
   logic [INDEX_W-1:0]         index_out_ff;

   assign nv64      = {nv_ff, 6'b0};
   assign den_in    = DEN_W'(hm2_ff) + DEN_W'(nv64);
   assign fade_prod = FP_W'(hm2_ff) * FP_W'(FADE_NUM);
   assign fade_in   = (fade_prod < FP_W'(nv64)) || (den_in == '0);
   assign abs_re    = num_re_ff[NUM_W-1] ? -num_re_ff : num_re_ff;
   assign abs_im    = num_im_ff[NUM_W-1] ? -num_im_ff : num_im_ff;

   // round to nearest: |num| * 2^13 + D/2
   assign dvd_re = {mag_re_ff, 13'b0} + DIVD_W'(den_ff[DEN_W-1:1]);
   assign dvd_im = {mag_im_ff, 13'b0} + DIVD_W'(den_ff[DEN_W-1:1]);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         y_re_ff <= req_y_re;
         y_im_ff <= req_y_im;
         h_re_ff <= req_h_re;
         h_im_ff <= req_h_im;
         nv_ff   <= req_noise_present ? req_noise_pwr : NV_FLOOR;
         idx_ff  <= cmd.data_index;
      end
      if (cmd.do_mul) begin
         p_rr_ff  <= PROD_W'(h_re_ff) * PROD_W'(h_re_ff);
         p_ii_ff  <= PROD_W'(h_im_ff) * PROD_W'(h_im_ff);
         p_ryr_ff <= PROD_W'(h_re_ff) * PROD_W'(y_re_ff);
         p_iyi_ff <= PROD_W'(h_im_ff) * PROD_W'(y_im_ff);
         p_ryi_ff <= PROD_W'(h_re_ff) * PROD_W'(y_im_ff);
         p_iyr_ff <= PROD_W'(h_im_ff) * PROD_W'(y_re_ff);
      end
      if (cmd.do_sum) begin
         hm2_ff    <= p_rr_ff + p_ii_ff;
         num_re_ff <= NUM_W'(p_ryr_ff) + NUM_W'(p_iyi_ff);
         num_im_ff <= NUM_W'(p_ryi_ff) - NUM_W'(p_iyr_ff);
      end
      if (cmd.do_den) begin
         den_ff    <= den_in;
         fade_ff   <= fade_in;
         neg_re_ff <= num_re_ff[NUM_W-1];
         neg_im_ff <= num_im_ff[NUM_W-1];
         mag_re_ff <= abs_re[MAG_W-1:0];
         mag_im_ff <= abs_im[MAG_W-1:0];
      end
      if (cmd.out_load) begin
         eq_re_ff     <= fade_ff ? '0 : sat_sign(quo_re, ovf_re, neg_re_ff);
         eq_im_ff     <= fade_ff ? '0 : sat_sign(quo_im, ovf_im, neg_im_ff);
         fade_out_ff  <= fade_ff;
         index_out_ff <= idx_ff;
      end
   end

   ofdmeq_div u_div_re (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_re),
      .divisor  (den_ff),
      .quotient (quo_re),
      .overflow (ovf_re)
   );

   ofdmeq_div u_div_im (
      .clock    (clock),
      .load     (cmd.div_load),
      .step     (cmd.div_step),
      .dividend (dvd_im),
      .divisor  (den_ff),
      .quotient (quo_im),
      .overflow (ovf_im)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (rsp_ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.out_blocked = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_eq_re       = eq_re_ff;
   assign rsp_eq_im       = eq_im_ff;
   assign rsp_deep_fade   = fade_out_ff;
   assign rsp_data_index  = index_out_ff;

endmodule

// File: hdl/ofdmeq_ctrl.sv
// ----------------------------------------------------------------------------
// OFDM carrier equaliser controller
// Pilot spacing CSR, carrier position counters and the sequencing FSM.
// ----------------------------------------------------------------------------
module ofdmeq_ctrl #(
   parameter int MAX_USED_CARRIERS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_last_carrier,
   output logic                        req_ready,
   input  logic                        csr_valid,
   input  logic [4:0]                  csr_pilot_spacing,
   output logic                        csr_ready,
   output ofdmeq_pkg::ofdmeq_cmd_type  cmd,
   input  ofdmeq_pkg::ofdmeq_sts_type  sts
);
   import ofdmeq_pkg::*;

   localparam int               POS_W    = $clog2(MAX_USED_CARRIERS);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_USED_CARRIERS - 1);

   ofdmeq_state_type     state_ff, state_in;
   logic [SPACING_W-1:0] spacing_ff, spacing_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [INDEX_W-1:0]   dcount_ff, dcount_in;
   logic [DCNT_W-1:0]    step_ff, step_in;
   logic [SPACING_W-1:0] sp_eff;
   logic [PHASE_W-1:0]   sp_m1;
   logic                 accept, is_pilot;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign is_pilot  = (phase_ff == '0);
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      if (spacing_ff == '0)              sp_eff = SPACING_W'(1);
      else if (spacing_ff > SPACING_MAX) sp_eff = SPACING_MAX;
      else                               sp_eff = spacing_ff;
   end
   assign sp_m1 = PHASE_W'(sp_eff - SPACING_W'(1));

   // position counters step on every accepted word, pilot or not
   always_comb begin
      spacing_in = csr_valid ? csr_pilot_spacing : spacing_ff;
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      dcount_in  = dcount_ff;
      if (accept) begin
         phase_in  = (phase_ff >= sp_m1) ? '0 : phase_ff + 1'b1;
         dcount_in = is_pilot ? dcount_ff : dcount_ff + 1'b1;
         pos_in    = pos_ff + 1'b1;
         if (req_last_carrier || pos_ff >= POS_LAST) begin
            pos_in    = '0;
            phase_in  = '0;
            dcount_in = '0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && !is_pilot) state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_DEN;
         ST_DEN:  state_in = ST_PREP;
         ST_PREP: state_in = ST_DIV;
         ST_DIV:  if (step_ff == DCNT_W'(DIV_STEPS - 1)) state_in = ST_OUT;
         ST_OUT:  if (!sts.out_blocked) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.data_index = dcount_ff;
      step_in        = step_ff;
      case (state_ff)
         ST_IDLE: cmd.capture = accept && !is_pilot;
         ST_MUL:  cmd.do_mul  = 1'b1;
         ST_SUM:  cmd.do_sum  = 1'b1;
         ST_DEN:  cmd.do_den  = 1'b1;
         ST_PREP: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
         end
         ST_OUT:  cmd.out_load = !sts.out_blocked;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         spacing_ff <= SPACING_RESET;
         pos_ff     <= '0;
         phase_ff   <= '0;
         dcount_ff  <= '0;
         step_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         spacing_ff <= spacing_in;
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         dcount_ff  <= dcount_in;
         step_ff    <= step_in;
      end
   end

endmodule

// File: hdl/ofdm_mmse_carrier_equalizer.sv
// ----------------------------------------------------------------------------
// OFDM MMSE carrier equaliser
// One-tap MMSE equaliser for used carriers, pilots dropped by position.
// ----------------------------------------------------------------------------
//  req_ch carries one used carrier per word: Y, H, noise variance with its
//  present flag, and the last-carrier mark. rsp_ch carries one word per data
//  carrier: conj(H)*Y/(|H|^2+nv) in Q2.13, the deep fade flag and the data
//  index. Pilot positions (index a multiple of the spacing) give no word.
//  csr_ch writes pilot_spacing; it is always ready. The user must write it
//  only when idle; the block itself does not enforce this. A data carrier
//  goes from acceptance to the result register through capture, products,
//  sums, denominator and fade test, dividend set-up, then 17 steps of the two
//  restoring divider lanes (one quotient bit each), holding req_ch off; a pilot
//  leaves req_ch ready. req_ch.ready is high again the cycle after the result
//  is loaded, so the next carrier is taken while the result waits.
//  If rsp_ch stalls with a result still held, the next one waits in the
//  sequencer until the result register frees up.
//  Reset (synchronous) sets the spacing to 4 and clears the position,
//  phase and data counters; no result is pending afterwards.
// ----------------------------------------------------------------------------
module ofdm_mmse_carrier_equalizer #(
   parameter int MAX_USED_CARRIERS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   ofdmeq_req_if.sink   req_ch,
   ofdmeq_rsp_if.source rsp_ch,
   ofdmeq_csr_if.sink   csr_ch
);
   import ofdmeq_pkg::*;

   ofdmeq_cmd_type cmd;
   ofdmeq_sts_type sts;

   ofdmeq_ctrl #(
      .MAX_USED_CARRIERS (MAX_USED_CARRIERS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_last_carrier  (req_ch.last_carrier),
      .req_ready         (req_ch.ready),
      .csr_valid         (csr_ch.valid),
      .csr_pilot_spacing (csr_ch.pilot_spacing),
      .csr_ready         (csr_ch.ready),
      .cmd               (cmd),
      .sts               (sts)
   );

   ofdmeq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_y_re          (req_ch.y_re),
      .req_y_im          (req_ch.y_im),
      .req_h_re          (req_ch.h_re),
      .req_h_im          (req_ch.h_im),
      .req_noise_pwr     (req_ch.noise_pwr),
      .req_noise_present (req_ch.noise_present),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_eq_re         (rsp_ch.eq_re),
      .rsp_eq_im         (rsp_ch.eq_im),
      .rsp_deep_fade     (rsp_ch.deep_fade),
      .rsp_data_index    (rsp_ch.data_index)
   );

   // a data carrier is only captured on an accepted word
   a_capture_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (req_ch.valid && req_ch.ready))
      else $error("capture without accepted word");

   // a new result only appears after the sequencer loads one
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.out_load))
      else $error("result valid without load");

   // never overwrite a result the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.out_blocked)
      else $error("result overwritten while stalled");

   // divider steps start right after the load
   a_div_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> cmd.div_step)
      else $error("divider not stepped after load");

endmodule
